// File: rtl/core/vkdi_pkg.sv
// Shared constants, types and widths for the vertex key deduplication indexer.
package vkdi_pkg;

  localparam int TABLE_ENTRIES  = 1024;
  localparam int KEY_INDEX_BITS = 16;

  // Input index fields are 16 bits; keys keep at most that many low bits.
  localparam int IN_INDEX_W  = 16;
  localparam int KEY_FIELD_W = (KEY_INDEX_BITS < IN_INDEX_W) ? KEY_INDEX_BITS : IN_INDEX_W;

  // Each cell of the chain holds a fixed group of table entries.
  localparam int CELL_SLOTS = 32;
  localparam int CELL_COUNT = (TABLE_ENTRIES + CELL_SLOTS - 1) / CELL_SLOTS;
  localparam int SLOT_W     = $clog2(CELL_SLOTS);
  localparam int CELL_IDX_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  // Entry count and entry positions; the span covers every slot of the chain.
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int BASE_W = $clog2(CELL_COUNT * CELL_SLOTS + 1);

  localparam int VNUM_W      = 10;
  localparam int IN_TDATA_W  = 3 * IN_INDEX_W;
  localparam int OUT_TDATA_W = ((VNUM_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  // Bit positions of the flags in the result tuser.
  localparam int TUSER_IS_NEW = 0;
  localparam int TUSER_FULL   = 1;

  typedef struct packed {
    logic [KEY_FIELD_W-1:0] pos;
    logic [KEY_FIELD_W-1:0] nrm;
    logic [KEY_FIELD_W-1:0] tex;
  } key_t;

  // Lookup record that walks down the chain, one cell per cycle.
  typedef struct packed {
    logic              valid;
    key_t              key;
    logic [BASE_W-1:0] len;
    logic [BASE_W-1:0] base;
    logic              found;
    logic [BASE_W-1:0] idx;
  } probe_t;

  // Insert command broadcast from the chain tail to all cells.
  typedef struct packed {
    logic                  en;
    logic [CELL_IDX_W-1:0] cell_sel;
    logic [SLOT_W-1:0]     slot;
    key_t                  key;
  } wr_cmd_t;

endpackage

// File: rtl/core/vkdi_cell.sv
// One chain cell: a group of stored keys, a local match and a probe register.
module vkdi_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [vkdi_pkg::CELL_IDX_W-1:0] cell_id,
  input  vkdi_pkg::wr_cmd_t               wr,
  input  vkdi_pkg::probe_t                probe_in,
  output vkdi_pkg::probe_t                probe_out
);
  import vkdi_pkg::*;

  key_t              keys_r [CELL_SLOTS];
  probe_t            probe_r;
  probe_t            probe_nxt;
  logic [CELL_SLOTS-1:0] hit;
  logic [SLOT_W-1:0] hit_slot;
  logic [BASE_W-1:0] room;

  always_ff @(posedge clk) begin
    if (wr.en && (wr.cell_sel == cell_id)) begin
      keys_r[wr.slot] <= wr.key;
    end
  end

  // Number of table entries from this cell's base up to the table length; only slots below it can match.
  assign room = (probe_in.len > probe_in.base) ? (probe_in.len - probe_in.base) : '0;

  always_comb begin
    hit      = '0;
    hit_slot = '0;
    for (int s = 0; s < CELL_SLOTS; s++) begin
      hit[s] = (keys_r[s] == probe_in.key) && (BASE_W'(s) < room);
    end
    // Stored keys are distinct, so at most one slot can match.
    for (int s = 0; s < CELL_SLOTS; s++) begin
      if (hit[s]) begin
        hit_slot = hit_slot | SLOT_W'(s);
      end
    end
  end

  always_comb begin
    probe_nxt       = probe_in;
    probe_nxt.base  = probe_in.base + BASE_W'(CELL_SLOTS);
    probe_nxt.found = probe_in.found | (|hit);
    probe_nxt.idx   = probe_in.found ? probe_in.idx
                                     : (probe_in.base + BASE_W'(hit_slot));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.valid <= 1'b0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  assign probe_out = probe_r;

endmodule

// File: rtl/core/vertex_key_dedup_indexer_unit.sv
// Top level of the vertex key deduplication indexer: head, cell chain, tail and output.
//
// Input beats carry one mesh corner: in_tdata holds the position, normal and
// texture-coordinate indices, in_tuser the start-of-shape flag. Each accepted
// beat produces exactly one output beat with the corner's dense vertex number
// in out_tdata and the is_new and table_full flags in out_tuser.
//
// A lookup walks a chain of CELL_COUNT cells (32 for a 1024-entry table), one
// cell per cycle, each cell comparing the key against its own group of 32
// stored entries. One item is in the chain at a time: an item passes the head
// register, the probe register of each cell and the output register, and the
// input takes no new item until the last one has left the chain tail.
// New keys are written into their cell as the lookup leaves the chain tail.
//
// Reset empties the table (the entry count goes to zero) and clears all
// pending work; the block is ready the cycle after reset is released.
// A finished result waits in the output register while the next item is
// taken; a second result that finds the receiver still stalled is held in a
// spill register, and input is refused until that spill register drains.
module vertex_key_dedup_indexer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] pos_idx, [31:16] nrm_idx, [47:32] tex_idx
  input  logic [vkdi_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] start_of_shape
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [9:0] vertex_number, [15:10] zero
  output logic [vkdi_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] is_new, [1] table_full
  output logic [vkdi_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import vkdi_pkg::*;

  typedef struct packed {
    logic [VNUM_W-1:0] vnum;
    logic              is_new;
    logic              full;
  } result_t;

  probe_t            chain [CELL_COUNT+1];
  probe_t            head_r;
  probe_t            head_nxt;
  probe_t            tail;
  wr_cmd_t           wr;
  logic [CNT_W-1:0]  count_r;
  logic              busy_r;
  logic              out_valid_r;
  result_t           out_r;
  logic              spill_valid_r;
  result_t           spill_r;
  result_t           res;
  logic              in_fire;
  logic              out_fire;
  logic              has_room;
  logic              do_insert;

  assign in_tready = !busy_r && !spill_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  always_comb begin
    head_nxt           = head_r;
    head_nxt.valid     = in_fire;
    head_nxt.key.pos   = in_tdata[KEY_FIELD_W-1:0];
    head_nxt.key.nrm   = in_tdata[IN_INDEX_W +: KEY_FIELD_W];
    head_nxt.key.tex   = in_tdata[2*IN_INDEX_W +: KEY_FIELD_W];
    head_nxt.len       = in_tuser ? '0 : BASE_W'(count_r);
    head_nxt.base      = '0;
    head_nxt.found     = 1'b0;
    head_nxt.idx       = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.valid <= 1'b0;
    end else begin
      head_r <= head_nxt;
    end
  end

  assign chain[0] = head_r;

  for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
    vkdi_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_id   (CELL_IDX_W'(k)),
      .wr        (wr),
      .probe_in  (chain[k]),
      .probe_out (chain[k+1])
    );
  end

  assign tail = chain[CELL_COUNT];

  // A miss is appended at the current length unless the table is full.
  assign has_room  = tail.len < BASE_W'(TABLE_ENTRIES);
  assign do_insert = tail.valid && !tail.found && has_room;

  always_comb begin
    wr.en       = do_insert;
    wr.cell_sel = CELL_IDX_W'(tail.len >> SLOT_W);
    wr.slot     = tail.len[SLOT_W-1:0];
    wr.key      = tail.key;
  end

  always_comb begin
    res.is_new = !tail.found && has_room;
    res.full   = !tail.found && !has_room;
    if (tail.found) begin
      res.vnum = VNUM_W'(tail.idx);
    end else if (has_room) begin
      res.vnum = VNUM_W'(tail.len);
    end else begin
      res.vnum = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      busy_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      spill_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_r <= 1'b1;
      end
      if (tail.valid) begin
        busy_r  <= 1'b0;
        count_r <= CNT_W'(tail.len) + CNT_W'(do_insert);
      end
      // The tail and a full spill register never meet: input waits on the spill.
      if (tail.valid) begin
        if (!out_valid_r || out_tready) begin
          out_valid_r <= 1'b1;
          out_r       <= res;
        end else begin
          spill_valid_r <= 1'b1;
          spill_r       <= res;
        end
      end else if (out_fire) begin
        out_valid_r   <= spill_valid_r;
        out_r         <= spill_r;
        spill_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid              = out_valid_r;
  assign out_tdata               = OUT_TDATA_W'(out_r.vnum);
  assign out_tuser[TUSER_IS_NEW] = out_r.is_new;
  assign out_tuser[TUSER_FULL]   = out_r.full;

endmodule

// File: rtl/core/vkdi_checker.sv
// Port-level checks for the vertex key deduplication indexer, bound to the top level.
module vkdi_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [vkdi_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [vkdi_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import vkdi_pkg::*;

  // A stalled output beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // A corner is either appended or rejected for lack of room, never both.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[TUSER_IS_NEW] && out_tuser[TUSER_FULL]))
    else $error("is_new and table_full both set");

  // A rejected corner reports vertex number zero.
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[TUSER_FULL] |-> out_tdata == '0)
    else $error("table_full beat with nonzero vertex number");

  // Only one corner is looked up at a time.
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a lookup is in flight");

endmodule

bind vertex_key_dedup_indexer_unit vkdi_checker u_vkdi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: tb/sv/vkdi_corner_checker.sv
// Checker for the vertex key deduplication indexer: predicts each corner's result and compares.
module vkdi_corner_checker
  import vkdi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  output int                     mismatches,
  output int                     pending,
  output int                     new_count,
  output int                     hit_count,
  output int                     full_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [VNUM_W-1:0] vertex_number;
    logic              is_new;
    logic              table_full;
  } corner_result_t;

  // Our own copy of the distinct triples of the current shape.
  key_t           shape_keys [TABLE_ENTRIES];
  int             shape_size;
  corner_result_t awaited_results [$];

  initial begin
    mismatches = 0;
    pending    = 0;
    new_count  = 0;
    hit_count  = 0;
    full_count = 0;
    shape_size = 0;
  end

  function automatic corner_result_t index_corner(logic start_of_shape, key_t key);
    corner_result_t res;
    if (start_of_shape) begin
      shape_size = 0;
    end
    for (int i = 0; i < shape_size; i++) begin
      if (shape_keys[i] == key) begin
        res.vertex_number = VNUM_W'(i);
        res.is_new        = 1'b0;
        res.table_full    = 1'b0;
        hit_count++;
        return res;
      end
    end
    if (shape_size >= TABLE_ENTRIES) begin
      res.vertex_number = '0;
      res.is_new        = 1'b0;
      res.table_full    = 1'b1;
      full_count++;
      return res;
    end
    shape_keys[shape_size] = key;
    res.vertex_number = VNUM_W'(shape_size);
    res.is_new        = 1'b1;
    res.table_full    = 1'b0;
    shape_size++;
    new_count++;
    return res;
  endfunction

  always @(posedge clk) begin
    corner_result_t           exp;
    key_t                     key;
    logic [OUT_TDATA_W-1:0]   exp_data;
    if (rst_n) begin
      // The result side is handled first so a beat is never matched to a corner
      // accepted on the same edge.
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] unexpected result beat: tdata=%h tuser=%b",
                     $realtime, out_tdata, out_tuser);
          end
        end else begin
          exp = awaited_results.pop_front();
          exp_data = '0;
          exp_data[VNUM_W-1:0] = exp.vertex_number;
          if (out_tdata !== exp_data || out_tuser[TUSER_IS_NEW] !== exp.is_new ||
              out_tuser[TUSER_FULL] !== exp.table_full) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result mismatch: expected vnum=%0d new=%b full=%b,",
                       $realtime, exp.vertex_number, exp.is_new, exp.table_full,
                       " got tdata=%h new=%b full=%b",
                       out_tdata, out_tuser[TUSER_IS_NEW], out_tuser[TUSER_FULL]);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        key.pos = in_tdata[KEY_FIELD_W-1:0];
        key.nrm = in_tdata[IN_INDEX_W +: KEY_FIELD_W];
        key.tex = in_tdata[2*IN_INDEX_W +: KEY_FIELD_W];
        awaited_results.push_back(index_corner(in_tuser, key));
      end
      pending <= awaited_results.size();
    end
  end

endmodule

// File: tb/sv/vertex_key_dedup_indexer_unit_tb.sv
// Testbench top for the vertex key deduplication indexer: stimulus, stalls and verdict.
module vertex_key_dedup_indexer_unit_tb;
  import vkdi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = CELL_COUNT + 16;
  localparam int RANDOM_TARGET = 500;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  int   mismatches;
  int   pending;
  int   new_count;
  int   hit_count;
  int   full_count;
  int   corners_sent;
  int   shapes_sent;
  int   cycle_count;
  logic calm;

  logic [47:0] corner_pool [0:23];
  logic [47:0] filled_keys [TABLE_ENTRIES];

  vertex_key_dedup_indexer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  vkdi_corner_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .pending    (pending),
    .new_count  (new_count),
    .hit_count  (hit_count),
    .full_count (full_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver stalls at random except during the calm stretch.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = calm ? 1'b1 : ($urandom_range(99) >= 14);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_corner(input logic sos, input logic [15:0] p, input logic [15:0] n,
                             input logic [15:0] t);
    while (!calm && $urandom_range(99) < 14) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = sos;
    in_tdata  = {t, n, p};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    corners_sent++;
    if (sos) shapes_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // One shape of corners drawn mostly from a small pool, so repeats are common.
  // Some pool keys differ from their neighbor in one field only.
  task automatic random_shape(input int length);
    int          pool_size;
    int          fld;
    logic [47:0] k;
    logic        sos;
    pool_size = $urandom_range(24, 2);
    for (int i = 0; i < pool_size; i++) begin
      if (i > 0 && $urandom_range(3) == 0) begin
        k = corner_pool[i-1];
        fld = $urandom_range(2);
        k[fld*16 +: 16] = 16'($urandom);
      end else begin
        k[31:0]  = $urandom;
        k[47:32] = 16'($urandom);
      end
      corner_pool[i] = k;
    end
    for (int j = 0; j < length; j++) begin
      if ($urandom_range(9) == 0) begin
        sos      = ($urandom_range(4) == 0);
        k[31:0]  = $urandom;
        k[47:32] = 16'($urandom);
      end else begin
        sos = (j == 0);
        k   = corner_pool[$urandom_range(pool_size - 1)];
      end
      send_corner(sos, k[15:0], k[31:16], k[47:32]);
    end
  endtask

  // Fills one shape to every entry, then offers new triples and repeats, and restarts a shape.
  task automatic fill_table();
    logic [15:0] base;
    logic [47:0] k;
    base = 16'($urandom);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      k[15:0]  = base + 16'(i);
      k[47:16] = $urandom;
      filled_keys[i] = k;
      send_corner(i == 0, k[15:0], k[31:16], k[47:32]);
    end
    send_corner(1'b0, base + 16'(TABLE_ENTRIES), 16'($urandom), 16'($urandom));
    k = filled_keys[0];
    send_corner(1'b0, k[15:0], k[31:16], k[47:32]);
    k = filled_keys[TABLE_ENTRIES-1];
    send_corner(1'b0, k[15:0], k[31:16], k[47:32]);
    send_corner(1'b0, base - 16'd1, 16'hFFFF, 16'h0000);
    for (int i = 0; i < 4; i++) begin
      k = filled_keys[$urandom_range(TABLE_ENTRIES - 1)];
      send_corner(1'b0, k[15:0], k[31:16], k[47:32]);
    end
    // A new shape must start numbering from zero again.
    k = filled_keys[5];
    send_corner(1'b1, k[15:0], k[31:16], k[47:32]);
    send_corner(1'b0, k[15:0], k[31:16], k[47:32]);
  endtask

  initial begin
    int random_sent;
    int len;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    calm         = 1'b0;
    corners_sent = 0;
    shapes_sent  = 0;
    cycle_count  = 0;
    random_sent  = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Extremes of every field, hits, near misses and restarting a shape.
    send_corner(1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_corner(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_corner(1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_corner(1'b0, 16'hFFFF, 16'h0000, 16'h0000);
    send_corner(1'b0, 16'h0000, 16'hFFFF, 16'h0000);
    send_corner(1'b0, 16'h0000, 16'h0000, 16'hFFFF);
    send_corner(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_corner(1'b0, 16'h5555, 16'hAAAA, 16'h5555);
    send_corner(1'b0, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_corner(1'b0, 16'h5555, 16'hAAAA, 16'h5555);
    send_corner(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_corner(1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_corner(1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_corner(1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_corner(1'b0, 16'h8000, 16'h0001, 16'h8000);

    // Let the pipeline empty completely before the long fill.
    wait_drained();
    @(negedge clk);
    fill_table();

    while (random_sent < RANDOM_TARGET) begin
      calm = (random_sent >= 150 && random_sent < 250);
      len  = ($urandom_range(7) == 0) ? $urandom_range(60, 20) : $urandom_range(16, 1);
      random_shape(len);
      random_sent += len;
    end
    calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d corners in %0d shapes: %0d appended, %0d matched,",
             corners_sent, shapes_sent, new_count, hit_count,
             " %0d refused on a full table.", full_count);
    $display("One shape was filled to all %0d entries before overflowing.", TABLE_ENTRIES);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
